/* rtl/core/tmef_pkg.sv */
// Package for the thermocouple median and average filter.
// Holds field widths, payload types, operation codes and the frame decode helpers.
// No dependencies; every other file of the block imports it.
`default_nettype none

package tmef_pkg;

  // Field widths fixed by the frame format and the result format.
  localparam int FRAME_W   = 32;
  localparam int CHAN_W    = 3;
  localparam int READ_W    = 14;
  localparam int FRAC_W    = 8;
  localparam int VALUE_W   = READ_W + FRAC_W;
  localparam int ALPHA_W   = 9;
  localparam int TAPS      = 5;
  localparam int POS_W     = 3;

  // Configuration port geometry.
  localparam int CFG_DW    = 32;
  localparam int CFG_AW    = 3;

  // Full weight of the new median, in 1/256 units.
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd77;

  // Converter frame layout.
  localparam int READ_MSB  = 31;
  localparam int READ_LSB  = 18;
  localparam int FAULT_W   = 3;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  // Register indexes on the configuration port.
  typedef enum logic {
    REG_ALPHA = 1'b0,
    REG_NONE  = 1'b1
  } reg_idx_t;

  typedef logic signed [READ_W-1:0]  reading_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [ALPHA_W-1:0]        alpha_t;
  typedef logic [POS_W-1:0]          pos_t;
  typedef reading_t [TAPS-1:0]       window_t;

  // Signed quarter-degree reading from the frame.
  function automatic reading_t frame_reading(input logic [FRAME_W-1:0] frame);
    return reading_t'(frame[READ_MSB:READ_LSB]);
  endfunction

  // Any of the three fault flags set.
  function automatic logic frame_fault(input logic [FRAME_W-1:0] frame);
    return |frame[FAULT_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/tmef_if.sv */
// Stream interfaces for the filter: sample beats in, result beats out.
// Depends on tmef_pkg for the payload types.
`default_nettype none

interface tmef_in_if
  import tmef_pkg::*;
();
  logic                 valid;
  logic                 ready;
  op_t                  op;
  logic [CHAN_W-1:0]    channel;
  logic [FRAME_W-1:0]   frame;

  modport source (output valid, output op, output channel, output frame, input ready);
  modport sink   (input valid, input op, input channel, input frame, output ready);
endinterface

interface tmef_out_if
  import tmef_pkg::*;
();
  logic   valid;
  logic   ready;
  logic   fault;
  value_t filtered;
  value_t lowest;
  value_t highest;
  logic   extremes_valid;

  modport source (output valid, output fault, output filtered, output lowest,
                  output highest, output extremes_valid, input ready);
  modport sink   (input valid, input fault, input filtered, input lowest,
                  input highest, input extremes_valid, output ready);
endinterface

`default_nettype wire

/* rtl/core/tmef_median5.sv */
// Median of five signed readings by a fixed min/max network.
// Depends on tmef_pkg for the reading and window types.
`default_nettype none

module tmef_median5
  import tmef_pkg::*;
(
  input  window_t  taps,
  output reading_t median
);

  reading_t lo_ab, hi_ab, lo_cd, hi_cd;
  reading_t mid_lo, mid_hi;
  reading_t e;

  // Pair sort, then the larger of the pair minimums and the smaller of the maximums.
  always_comb begin
    lo_ab  = (taps[0] < taps[1]) ? taps[0] : taps[1];
    hi_ab  = (taps[0] < taps[1]) ? taps[1] : taps[0];
    lo_cd  = (taps[2] < taps[3]) ? taps[2] : taps[3];
    hi_cd  = (taps[2] < taps[3]) ? taps[3] : taps[2];
    mid_lo = (lo_ab > lo_cd) ? lo_ab : lo_cd;
    mid_hi = (hi_ab < hi_cd) ? hi_ab : hi_cd;
    e      = taps[4];
  end

  // The median of five is the median of the fifth tap and those two.
  always_comb begin
    if ((e >= mid_lo && e <= mid_hi) || (e <= mid_lo && e >= mid_hi)) begin
      median = e;
    end else if ((mid_lo >= e && mid_lo <= mid_hi) || (mid_lo <= e && mid_lo >= mid_hi)) begin
      median = mid_lo;
    end else begin
      median = mid_hi;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tmef_ema.sv */
// Exponential average step: (alpha*med*256 + (256-alpha)*avg) >> 8, floor rounding.
// Depends on tmef_pkg for the value, reading and weight types.
`default_nettype none

module tmef_ema
  import tmef_pkg::*;
(
  input  alpha_t   alpha,
  input  reading_t median,
  input  value_t   average,
  output value_t   result
);

  localparam int TERM_A_W = ALPHA_W + 1 + READ_W;
  localparam int TERM_B_W = ALPHA_W + 1 + VALUE_W;
  localparam int SUM_W    = TERM_B_W + 1;

  alpha_t                     weight;
  alpha_t                     rest;
  logic signed [TERM_A_W-1:0] term_a;
  logic signed [TERM_B_W-1:0] term_b;
  logic signed [SUM_W-1:0]    sum;

  // Saturate the weight to one, then form both weighted terms.
  always_comb begin
    weight = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
    rest   = ALPHA_ONE - weight;
    term_a = $signed({1'b0, weight}) * median;
    term_b = $signed({1'b0, rest}) * average;
    sum    = SUM_W'({term_a, {FRAC_W{1'b0}}}) + SUM_W'(term_b);
  end

  // Arithmetic shift floors; the weighted mean always fits the value width.
  assign result = value_t'(sum >>> FRAC_W);

endmodule

`default_nettype wire

/* rtl/core/thermocouple_median_ema_filter_unit.sv */
// Top level of the per-channel median-of-five plus exponential average filter.
// Depends on tmef_pkg, tmef_if, tmef_median5 and tmef_ema.
//
//   port     role     beat contents
//   in_bus   sink     op, channel, frame
//   out_bus  source   fault, filtered, lowest, highest, extremes_valid
//   psel...  APB      alpha_q8 at byte address 0
//
// One beat per clock while out_bus is not stalled: a beat is registered on acceptance,
// and when the input stage advances, the median network and the two weight multipliers
// update the channel state and load the output register, which drives out_bus.valid.
// Reset clears the ring positions, primed flags and record flags at once; window,
// average and records are written before they are read.
// When out_bus is stalled the input stage still takes one beat, then in_bus.ready drops.
`default_nettype none

module thermocouple_median_ema_filter_unit
  import tmef_pkg::*;
#(
  parameter int CHANNELS = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready,
  tmef_in_if.sink            in_bus,
  tmef_out_if.source         out_bus
);

  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_EXT  = 5;

  // Configuration register.
  alpha_t   alpha_r;
  reg_idx_t reg_idx;
  logic     cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
    end else if (cfg_write && reg_idx == REG_ALPHA) begin
      alpha_r <= pwdata[ALPHA_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ALPHA: prdata = CFG_DW'(alpha_r);
      default:   prdata = '0;
    endcase
  end

  // Input stage.
  logic               s1_valid_r;
  op_t                s1_op_r;
  logic [CHAN_W-1:0]  s1_chan_r;
  logic [FRAME_W-1:0] s1_frame_r;
  logic               s1_adv;
  logic               s1_fire;
  logic               out_valid_r;

  assign s1_adv       = !out_valid_r || out_bus.ready;
  assign s1_fire      = s1_valid_r && s1_adv;
  assign in_bus.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      s1_op_r    <= in_bus.op;
      s1_chan_r  <= in_bus.channel;
      s1_frame_r <= in_bus.frame;
    end
  end

  // Per-channel state.
  window_t win_r     [CHANNELS];
  pos_t    pos_r     [CHANNELS];
  logic    primed_r  [CHANNELS];
  value_t  avg_r     [CHANNELS];
  value_t  low_r     [CHANNELS];
  value_t  high_r    [CHANNELS];
  logic    rvalid_r  [CHANNELS];

  // Decode of the registered beat.
  logic [CH_EXT-1:0] chan_ext;
  logic [CH_W-1:0]   ch_idx;
  logic              chan_ok;
  logic              fault;
  reading_t          reading;
  logic              do_clear;
  logic              do_update;

  always_comb begin
    chan_ext  = CH_EXT'(s1_chan_r);
    ch_idx    = chan_ext[CH_W-1:0];
    chan_ok   = chan_ext < CH_EXT'(CHANNELS);
    fault     = frame_fault(s1_frame_r);
    reading   = frame_reading(s1_frame_r);
    do_clear  = s1_fire && s1_op_r == OP_CLEAR;
    do_update = s1_fire && s1_op_r == OP_SAMPLE && chan_ok && !fault;
  end

  // Window row with the new reading placed, and the next ring position.
  window_t  row_old;
  window_t  row_new;
  pos_t     pos_eff;
  pos_t     pos_nxt;
  logic     primed;
  value_t   avg_old;
  reading_t median;
  value_t   ema;
  value_t   value;
  value_t   low_nxt;
  value_t   high_nxt;

  always_comb begin
    row_old = win_r[ch_idx];
    primed  = primed_r[ch_idx];
    avg_old = avg_r[ch_idx];
    pos_eff = (pos_r[ch_idx] >= POS_W'(TAPS)) ? '0 : pos_r[ch_idx];
    for (int t = 0; t < TAPS; t++) begin
      row_new[t] = (!primed || pos_eff == POS_W'(t)) ? reading : row_old[t];
    end
    if (!primed) begin
      pos_nxt = '0;
    end else if (pos_eff == POS_W'(TAPS - 1)) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_eff + POS_W'(1);
    end
  end

  tmef_median5 u_median (
    .taps   (row_new),
    .median (median)
  );

  tmef_ema u_ema (
    .alpha   (alpha_r),
    .median  (median),
    .average (avg_old),
    .result  (ema)
  );

  // New average and running extremes.
  always_comb begin
    value = primed ? ema : value_t'({reading, {FRAC_W{1'b0}}});
    if (!rvalid_r[ch_idx]) begin
      low_nxt  = value;
      high_nxt = value;
    end else begin
      low_nxt  = (value < low_r[ch_idx])  ? value : low_r[ch_idx];
      high_nxt = (value > high_r[ch_idx]) ? value : high_r[ch_idx];
    end
  end

  // Control state of each channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pos_r[i]    <= '0;
        primed_r[i] <= 1'b0;
        rvalid_r[i] <= 1'b0;
      end
    end else begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (do_clear) begin
          rvalid_r[i] <= 1'b0;
        end else if (do_update && ch_idx == CH_W'(i)) begin
          rvalid_r[i] <= 1'b1;
        end
        if (do_update && ch_idx == CH_W'(i)) begin
          pos_r[i]    <= pos_nxt;
          primed_r[i] <= 1'b1;
        end
      end
    end
  end

  // Data state of each channel.
  always_ff @(posedge clk) begin
    for (int i = 0; i < CHANNELS; i++) begin
      if (do_update && ch_idx == CH_W'(i)) begin
        win_r[i]  <= row_new;
        avg_r[i]  <= value;
        low_r[i]  <= low_nxt;
        high_r[i] <= high_nxt;
      end
    end
  end

  // Output register.
  logic   out_fault_r;
  value_t out_filt_r;
  value_t out_low_r;
  value_t out_high_r;
  logic   out_ev_r;
  logic   fault_beat;

  assign fault_beat = s1_op_r == OP_SAMPLE && chan_ok && fault;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_fault_r <= fault_beat;
      out_ev_r    <= do_update;
      out_filt_r  <= do_update ? value    : '0;
      out_low_r   <= do_update ? low_nxt  : '0;
      out_high_r  <= do_update ? high_nxt : '0;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.fault          = out_fault_r;
  assign out_bus.filtered       = out_filt_r;
  assign out_bus.lowest         = out_low_r;
  assign out_bus.highest        = out_high_r;
  assign out_bus.extremes_valid = out_ev_r;

  // A clear beat leaves every channel without records; this check watches channel 0.
  a_clear_drops_records: assert property (@(posedge clk) disable iff (!rst_n)
    do_clear |=> !rvalid_r[0])
    else $error("record flag survived a clear beat");

  // A fault beat never carries a recorded range.
  a_fault_no_extremes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fault_r |-> !out_ev_r)
    else $error("fault beat reports extremes");

  // The filtered value lies within the reported range.
  a_value_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ev_r |-> (out_low_r <= out_filt_r) && (out_filt_r <= out_high_r))
    else $error("filtered value outside its channel range");

  // A stalled output stage keeps the input stage from taking a second beat.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_bus.ready && s1_valid_r |-> !in_bus.ready)
    else $error("input taken while both stages are full");

endmodule

`default_nettype wire
